FILE: design/sorted_list_table_core_macros.svh
// ----------------------------------------------------------------------------
// sorted list table assertion macros
// concurrent checks sampled on clk, held off during rst
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_CORE_MACROS_SVH
`define SORTED_LIST_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SLT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// shared types and constants of the sorted list table
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int VALUE_W   = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 3;
  localparam int TOTAL_W   = 8;
  localparam int M_TDATA_W = VALUE_W + TOTAL_W;
  localparam int M_TUSER_W = STATUS_W + 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT       = 3'd0,
    ACT_DELETE       = 3'd1,
    ACT_LOOKUP       = 3'd2,
    ACT_RESET_CURSOR = 3'd3,
    ACT_READ_NEXT    = 3'd4,
    ACT_CLEAR        = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DUP       = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_NO_MORE   = 3'd4
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic capture;
    logic ins;
    logic del;
    logic clr;
  } cell_ctrl_t;

endpackage

FILE: design/slt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_cell
// one slot of the sorted row: holds an entry, compares it with the key and
// takes a neighbor's entry when the row shifts
// ----------------------------------------------------------------------------
module slt_cell #(
  parameter int CNT_W = 8,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  slt_pkg::cell_ctrl_t         ctrl,
  input  logic [slt_pkg::VALUE_W-1:0] key,
  input  logic [CNT_W-1:0]            cursor,
  input  logic [slt_pkg::VALUE_W-1:0] left_entry,
  input  logic                        left_valid,
  input  logic                        left_ge,
  input  logic [slt_pkg::VALUE_W-1:0] right_entry,
  input  logic                        right_valid,
  output logic [slt_pkg::VALUE_W-1:0] entry,
  output logic                        valid,
  output logic                        ge,
  output logic                        hit,
  output logic [slt_pkg::VALUE_W-1:0] pick
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic                        lt;
  logic                        eq;
  logic [slt_pkg::VALUE_W-1:0] entry_next;
  logic                        valid_next;

  assign ge   = !(valid && lt);
  assign hit  = valid && eq;
  assign pick = (cursor == IDX) ? entry : '0;

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (ctrl.clr) begin
      valid_next = 1'b0;
    end else if (ctrl.ins) begin
      valid_next = left_valid;
      if (ge) begin
        entry_next = left_ge ? left_entry : key;
      end
    end else if (ctrl.del && ge) begin
      entry_next = right_entry;
      valid_next = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt <= $signed(entry) < $signed(key);
      eq <= entry == key;
    end
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

FILE: design/sorted_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_core
// ascending table of signed words held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser                       | tlast
// s       | in  | value[31:0]                    | action[2:0]                 | -
// m       | out | read_value[31:0] total[39:32]  | status[2:0] found is_empty  | is_last
//         |     |                                | is_full (bits 3..5)         |
//
// accept, then commit: every cell compares its entry with the key at the
// accept edge, the commit state reduces the cell flags and shifts the row
// reset clears count, cursor and the cell valid bits at once, no sweep
// a result waiting on m does not block accept, it holds the commit cycle
// ----------------------------------------------------------------------------
`include "sorted_list_table_core_macros.svh"

module sorted_list_table_core #(
  parameter int CAPACITY = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [slt_pkg::VALUE_W-1:0]   s_tdata,  // value
  input  logic [slt_pkg::ACTION_W-1:0]  s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slt_pkg::M_TDATA_W-1:0] m_tdata,  // read_value, entry_total
  output logic [slt_pkg::M_TUSER_W-1:0] m_tuser,  // status, found, is_empty, is_full
  output logic                          m_tlast   // is_last
);

  localparam int               CNT_W = $clog2(CAPACITY + 1);
  localparam int               VW    = slt_pkg::VALUE_W;
  localparam int               TW    = slt_pkg::TOTAL_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic {ST_IDLE, ST_COMMIT} state_t;

  state_t              state;
  slt_pkg::action_t    action_q;
  logic [VW-1:0]       key_q;
  logic [VW-1:0]       key_bus;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cursor;
  logic [CNT_W-1:0]    cursor_next;
  slt_pkg::cell_ctrl_t ctrl;
  slt_pkg::status_t    status;
  logic                found;
  logic                go;
  logic                any_hit;
  logic [VW-1:0]       rd;
  logic [VW-1:0]       rd_word;

  logic [VW-1:0]       entry_vec [CAPACITY];
  logic [VW-1:0]       pick_vec  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] hit_vec;

  assign s_tready = (state == ST_IDLE);
  assign key_bus  = (state == ST_IDLE) ? s_tdata : key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] l_entry;
    logic          l_valid;
    logic          l_ge;
    logic [VW-1:0] r_entry;
    logic          r_valid;

    if (i == 0) begin : g_head
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_ge    = 1'b0;
    end else begin : g_body
      assign l_entry = entry_vec[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_ge    = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_vec[i+1];
      assign r_valid = valid_vec[i+1];
    end

    slt_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key         (key_bus),
      .cursor      (cursor),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (entry_vec[i]),
      .valid       (valid_vec[i]),
      .ge          (ge_vec[i]),
      .hit         (hit_vec[i]),
      .pick        (pick_vec[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | pick_vec[i];
    end
  end

  always_comb begin
    go          = (state == ST_COMMIT) && (!m_tvalid || m_tready);
    any_hit     = |hit_vec;
    ctrl        = '0;
    ctrl.capture = s_tvalid && s_tready;
    count_next  = count;
    cursor_next = cursor;
    status      = slt_pkg::STAT_OK;
    found       = 1'b0;
    rd          = '0;
    case (action_q)
      slt_pkg::ACT_INSERT: begin
        if (count == CAP_C) begin
          status = slt_pkg::STAT_FULL;
        end else if (any_hit) begin
          status = slt_pkg::STAT_DUP;
        end else begin
          ctrl.ins   = go;
          count_next = count + CNT_W'(1);
        end
      end
      slt_pkg::ACT_DELETE: begin
        if (any_hit) begin
          found      = 1'b1;
          ctrl.del   = go;
          count_next = count - CNT_W'(1);
        end else begin
          status = slt_pkg::STAT_NOT_FOUND;
        end
      end
      slt_pkg::ACT_LOOKUP: begin
        if (any_hit) begin
          found = 1'b1;
        end else begin
          status = slt_pkg::STAT_NOT_FOUND;
        end
      end
      slt_pkg::ACT_RESET_CURSOR: begin
        cursor_next = '0;
      end
      slt_pkg::ACT_READ_NEXT: begin
        if (cursor >= count) begin
          status = slt_pkg::STAT_NO_MORE;
        end else begin
          rd          = rd_word;
          cursor_next = cursor + CNT_W'(1);
        end
      end
      slt_pkg::ACT_CLEAR: begin
        ctrl.clr   = go;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      cursor   <= '0;
    end else begin
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            action_q <= slt_pkg::action_t'(s_tuser);
            key_q    <= s_tdata;
            state    <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (go) begin
            m_tdata  <= {TW'(count_next), rd};
            m_tuser  <= {count_next == CAP_C, count_next == '0, found, status};
            m_tlast  <= cursor_next >= count_next;
            count    <= count_next;
            cursor   <= cursor_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SLT_ASSERT_SAME(a_count_range, 1'b1, count <= CAP_C, "entry count beyond capacity")
  `SLT_ASSERT_SAME(a_valid_count, 1'b1, $countones(valid_vec) == count, "valid bits vs count")
  `SLT_ASSERT_SAME(a_unique_hit, state == ST_COMMIT, $onehot0(hit_vec), "key hit in two cells")
  `SLT_ASSERT_NEXT(a_ins_grow, ctrl.ins, count == $past(count) + CNT_W'(1), "insert kept count")
  `SLT_ASSERT_NEXT(a_commit_presents, go, m_tvalid && state == ST_IDLE, "commit gave no result")

endmodule

FILE: tb/sv/sorted_list_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_checker
// watches both streams of the sorted list table, keeps its own ascending
// table with count and read cursor, predicts one result per request and
// compares every field of each result in order of arrival
// ----------------------------------------------------------------------------
module sorted_list_table_checker #(
  parameter int CAPACITY = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [slt_pkg::VALUE_W-1:0]   s_tdata,  // value
  input  logic [slt_pkg::ACTION_W-1:0]  s_tuser,  // action
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [slt_pkg::M_TDATA_W-1:0] m_tdata,  // read_value, entry_total
  input  logic [slt_pkg::M_TUSER_W-1:0] m_tuser,  // status, found, is_empty, is_full
  input  logic                          m_tlast,  // is_last
  output int                            fail_count,
  output int                            pending
);
  import slt_pkg::*;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [VALUE_W-1:0]  read_value;
    logic [TOTAL_W-1:0]  total;
    logic                empty;
    logic                full;
    logic                last;
  } table_result_t;

  logic signed [VALUE_W-1:0] store [CAPACITY];
  int                        held;
  int                        cursor;
  table_result_t             results_due [$];

  function automatic table_result_t table_step(input logic [ACTION_W-1:0] act,
                                               input logic signed [VALUE_W-1:0] key);
    table_result_t r;
    int pos;
    r = '0;
    r.status = STAT_OK;
    pos = 0;
    case (act)
      ACT_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          while (pos < held && store[pos] < key) pos++;
          if (pos < held && store[pos] == key) begin
            r.status = STAT_DUP;
          end else begin
            for (int k = held; k > pos; k--) store[k] = store[k-1];
            store[pos] = key;
            held++;
          end
        end
      end
      ACT_DELETE: begin
        while (pos < held && store[pos] != key) pos++;
        if (pos >= held) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          for (int k = pos + 1; k < held; k++) store[k-1] = store[k];
          held--;
        end
      end
      ACT_LOOKUP: begin
        // ascending order lets the search stop at the first larger entry
        for (pos = 0; pos < held; pos++) begin
          if (store[pos] == key) begin
            r.found = 1'b1;
            break;
          end
          if (key < store[pos]) break;
        end
        if (!r.found) r.status = STAT_NOT_FOUND;
      end
      ACT_RESET_CURSOR: cursor = 0;
      ACT_READ_NEXT: begin
        if (cursor >= held) begin
          r.status = STAT_NO_MORE;
        end else begin
          r.read_value = store[cursor];
          cursor++;
        end
      end
      ACT_CLEAR: held = 0;
      default: ;
    endcase
    r.total = held[TOTAL_W-1:0];
    r.empty = (held == 0);
    r.full  = (held == CAPACITY);
    r.last  = (cursor >= held);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      held = 0;
      cursor = 0;
      fail_count = 0;
      results_due.delete();
      for (int i = 0; i < CAPACITY; i++) store[i] = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, m_tuser[STATUS_W-1:0]);
          check_field("found", want.found, m_tuser[STATUS_W]);
          check_field("read_value", $signed(want.read_value),
                      $signed(m_tdata[VALUE_W-1:0]));
          check_field("entry_total", want.total, m_tdata[VALUE_W +: TOTAL_W]);
          check_field("is_empty", want.empty, m_tuser[STATUS_W+1]);
          check_field("is_full", want.full, m_tuser[STATUS_W+2]);
          check_field("is_last", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) results_due.push_back(table_step(s_tuser, s_tdata));
    end
    pending = results_due.size();
  end

endmodule

FILE: tb/sv/sorted_list_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_core_tb
// drives directed and random requests into the sorted list table with random
// gaps and back-pressure; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module sorted_list_table_core_tb;
  import slt_pkg::*;

  localparam int CAPACITY       = 128;
  localparam int REQUEST_TARGET = 1450;
  localparam int POOL_SIZE      = 24;
  localparam int FILL_SPAN      = CAPACITY + 5;
  localparam int FILL_STEP      = 37;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [VALUE_W-1:0]    s_tdata;
  logic [ACTION_W-1:0]   s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;
  int                    fail_count;
  int                    pending;
  int                    requests_sent;
  bit                    calm;
  logic [VALUE_W-1:0]    key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  sorted_list_table_core #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  sorted_list_table_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
  );

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ACT_INSERT;
    if (r < 55) return ACT_DELETE;
    if (r < 72) return ACT_LOOKUP;
    if (r < 77) return ACT_RESET_CURSOR;
    if (r < 93) return ACT_READ_NEXT;
    if (r < 95) return ACT_CLEAR;
    return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // keys near the signed extremes and around zero keep order edges busy
  function automatic void refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = 32'h8000_0000 + $urandom_range(0, 2);
        1:       key_pool[i] = 32'h7fff_ffff - $urandom_range(0, 2);
        2:       key_pool[i] = $urandom_range(0, 3) - 1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endfunction

  task automatic push_request(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] key);
    int gap;
    gap = calm ? 0 : idle_length();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = key;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  initial begin : sink_pacing
    int gap;
    forever begin
      m_tready = 1'b1;
      repeat (calm ? 8 : $urandom_range(1, 12)) @(negedge clk);
      gap = calm ? 0 : idle_length();
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] stride;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_INSERT;
    requests_sent = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, extremes, duplicate, misses, cursor past a shrinking count, spare actions, clear
    push_request(ACT_READ_NEXT, 32'hffff_ffff);
    push_request(ACT_LOOKUP, 32'h0000_0000);
    push_request(ACT_DELETE, 32'h0000_0000);
    push_request(ACT_INSERT, 32'h0000_0000);
    push_request(ACT_INSERT, 32'h7fff_ffff);
    push_request(ACT_INSERT, 32'h8000_0000);
    push_request(ACT_INSERT, 32'hffff_ffff);
    push_request(ACT_INSERT, 32'h0000_0000);
    push_request(ACT_LOOKUP, 32'hffff_ffff);
    push_request(ACT_LOOKUP, 32'h0000_0005);
    push_request(ACT_LOOKUP, 32'h7fff_fffe);
    push_request(ACT_RESET_CURSOR, 32'h5555_5555);
    repeat (4) push_request(ACT_READ_NEXT, 32'haaaa_aaaa);
    push_request(ACT_READ_NEXT, 32'h0000_0000);
    push_request(ACT_DELETE, 32'hffff_ffff);
    push_request(ACT_READ_NEXT, 32'h0000_0000);
    push_request(ACT_DELETE, 32'h0000_3039);
    push_request(ACT_SPARE_LO, 32'hffff_ffff);
    push_request(ACT_SPARE_HI, 32'h8000_0000);
    push_request(ACT_RESET_CURSOR, 32'h0000_0000);
    push_request(ACT_READ_NEXT, 32'h0000_0000);
    push_request(ACT_CLEAR, 32'h7fff_ffff);
    push_request(ACT_READ_NEXT, 32'h0000_0000);

    refresh_pool();
    while (requests_sent < REQUEST_TARGET) begin
      calm  = ($urandom_range(0, 4) == 0);
      phase = $urandom_range(0, 19);
      if (phase < 12) begin
        if ($urandom_range(0, 2) == 0) refresh_pool();
        repeat ($urandom_range(20, 80)) push_request(pick_action(), pick_key());
      end else if (phase < 15) begin
        push_request(ACT_RESET_CURSOR, $urandom);
        repeat ($urandom_range(1, 30)) push_request(ACT_READ_NEXT, $urandom);
      end else if (phase < 17) begin
        // distinct keys in scrambled order, overrunning the capacity
        base   = $urandom;
        stride = $urandom_range(1, 1 << 24);
        for (int j = 0; j < FILL_SPAN; j++)
          push_request(ACT_INSERT, base + stride * ((j * FILL_STEP) % FILL_SPAN));
        push_request(ACT_INSERT, base);
        push_request(ACT_RESET_CURSOR, $urandom);
        repeat ($urandom_range(5, 20)) push_request(ACT_READ_NEXT, $urandom);
        repeat ($urandom_range(5, 30)) begin
          push_request($urandom_range(0, 1) ? ACT_DELETE : ACT_LOOKUP,
                       base + stride * $urandom_range(0, FILL_SPAN - 1));
        end
        if ($urandom_range(0, 1) == 0) push_request(ACT_CLEAR, $urandom);
      end else if (phase < 18) begin
        push_request(ACT_CLEAR, $urandom);
        push_request(ACT_RESET_CURSOR, $urandom);
      end else begin
        repeat ($urandom_range(5, 20))
          push_request(ACTION_W'($urandom_range(0, (1 << ACTION_W) - 1)), $urandom);
      end
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
